// ===== sv/cedd_pkg.sv =====
`default_nettype none

package cedd_pkg;

  localparam int OPERATION_W  = 2;
  localparam int VERTEX_W     = 10;
  localparam int CLASS_CODE_W = 7;
  localparam int CLASS_OUT_W  = 6;
  localparam int LINK_W       = 12;

  // widest vertex address and class code the parameters allow, used for explicit extension
  localparam int ADDR_EXT_W = 17;
  localparam int CLS_EXT_W  = 8;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [OPERATION_W-1:0] {
    OP_ASSIGN = 2'd0,
    OP_EDGE   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef struct packed {
    op_e                    op;
    logic [VERTEX_W-1:0]    vertex;
    logic [VERTEX_W-1:0]    target;
    logic                   src_ok;
    logic                   tgt_ok;
    logic                   cls_ok;
    logic [CLASS_OUT_W-1:0] cls;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q2b_t;

  typedef struct packed {
    logic pop;
    logic sweeping;
  } b2f_t;

endpackage

`default_nettype wire

// ===== sv/cedd_front.sv =====
`default_nettype none

module cedd_front #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_CLASSES  = 64
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     start,
  output logic                                          busy,
  input  wire logic [cedd_pkg::OPERATION_W-1:0]         operation_i,
  input  wire logic [cedd_pkg::VERTEX_W-1:0]            vertex_i,
  input  wire logic signed [cedd_pkg::CLASS_CODE_W-1:0] class_code_i,
  input  wire logic [cedd_pkg::VERTEX_W-1:0]            target_vertex_i,
  output cedd_pkg::q2b_t                                q2b_o,
  input  wire cedd_pkg::b2f_t                           b2f_i
);

  localparam int PTR_W = (cedd_pkg::QUEUE_DEPTH > 1) ? $clog2(cedd_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(cedd_pkg::QUEUE_DEPTH + 1);

  cedd_pkg::cmd_t            entry_q [cedd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]          wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]          rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic                      full;
  logic                      accept;
  logic                      push;
  logic                      pop;
  logic                      op_known;
  cedd_pkg::cmd_t            cmd;
  logic [cedd_pkg::ADDR_EXT_W-1:0] vtx_ext;
  logic [cedd_pkg::ADDR_EXT_W-1:0] tgt_ext;
  logic [cedd_pkg::CLS_EXT_W:0]    cls_ext;

  // classify the incoming item
  always_comb begin
    vtx_ext = cedd_pkg::ADDR_EXT_W'(vertex_i);
    tgt_ext = cedd_pkg::ADDR_EXT_W'(target_vertex_i);
    cls_ext = (cedd_pkg::CLS_EXT_W + 1)'(class_code_i[cedd_pkg::CLASS_OUT_W-1:0]);
    op_known = 1'b0;
    unique case (cedd_pkg::op_e'(operation_i))
      cedd_pkg::OP_ASSIGN: op_known = 1'b1;
      cedd_pkg::OP_EDGE:   op_known = 1'b1;
      cedd_pkg::OP_CLEAR:  op_known = 1'b1;
      default:             op_known = 1'b0;
    endcase
    cmd.op     = cedd_pkg::op_e'(operation_i);
    cmd.vertex = vertex_i;
    cmd.target = target_vertex_i;
    cmd.src_ok = vtx_ext < cedd_pkg::ADDR_EXT_W'(MAX_VERTICES);
    cmd.tgt_ok = tgt_ext < cedd_pkg::ADDR_EXT_W'(MAX_VERTICES);
    // any negative code, or one beyond the class count, reads as unassigned
    cmd.cls_ok = !class_code_i[cedd_pkg::CLASS_CODE_W-1]
                 && (cls_ext < (cedd_pkg::CLS_EXT_W + 1)'(MAX_CLASSES));
    cmd.cls    = class_code_i[cedd_pkg::CLASS_OUT_W-1:0];
  end

  assign full   = count_q == CNT_W'(cedd_pkg::QUEUE_DEPTH);
  assign busy   = full || b2f_i.sweeping;
  assign accept = start && !busy;
  // unused operation code is taken and dropped here
  assign push   = accept && op_known;
  assign pop    = b2f_i.pop;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(cedd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(cedd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd;
    end
  end

  assign q2b_o.valid = count_q != '0;
  assign q2b_o.cmd   = entry_q[rd_ptr_q];

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(cedd_pkg::QUEUE_DEPTH))
    else $error("command queue count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> count_q != '0)
    else $error("pop from empty command queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("push into full command queue");
`endif

endmodule

`default_nettype wire

// ===== sv/cedd_back.sv =====
`default_nettype none

module cedd_back #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_CLASSES  = 64
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire cedd_pkg::q2b_t                      q2b_i,
  output cedd_pkg::b2f_t                           b2f_o,
  output logic                                     valid_o,
  output logic [cedd_pkg::CLASS_OUT_W-1:0]         source_class_o,
  output logic [cedd_pkg::CLASS_OUT_W-1:0]         target_class_o,
  output logic [cedd_pkg::LINK_W-1:0]              link_index_o
);

  localparam int VTX_AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CLS_W     = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int SWEEP_LEN = (MAX_VERTICES > MAX_CLASSES) ? MAX_VERTICES : MAX_CLASSES;
  localparam int SW_W      = $clog2(SWEEP_LEN);
  localparam int SWC_W     = SW_W + 1;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_MAP,
    ST_PAIR
  } state_e;

  // map entry: top bit marks an assigned vertex, the rest is its class
  typedef logic [CLS_W:0] map_entry_t;

  map_entry_t                   map_mem [MAX_VERTICES];
  logic [MAX_CLASSES-1:0]       pair_mem [MAX_CLASSES];

  state_e                       state_q;
  logic [SW_W-1:0]              sweep_q;
  logic [cedd_pkg::LINK_W-1:0]  link_q;
  logic                         src_ok_q, tgt_ok_q;
  logic [CLS_W-1:0]             cu_q, cv_q;
  logic                         valid_q;
  logic [cedd_pkg::CLASS_OUT_W-1:0] src_cls_q, tgt_cls_q;
  logic [cedd_pkg::LINK_W-1:0]  link_out_q;

  map_entry_t                   map_a_q, map_b_q;
  logic [MAX_CLASSES-1:0]       pair_row_q;

  cedd_pkg::cmd_t               head;
  logic                         pop;
  logic                         map_rd_en;
  logic [cedd_pkg::ADDR_EXT_W-1:0] src_ext, tgt_ext;
  logic [VTX_AW-1:0]            src_addr, tgt_addr;
  logic [cedd_pkg::CLS_EXT_W-1:0] cls_ext;
  logic                         map_we;
  logic [VTX_AW-1:0]            map_wa;
  map_entry_t                   map_wd;
  logic                         pair_rd_en;
  logic                         pair_we;
  logic [CLS_W-1:0]             pair_wa;
  logic [MAX_CLASSES-1:0]       pair_wd;
  logic                         hit;
  logic                         new_link;
  logic                         sweep_map, sweep_pair, sweep_last;
  logic [cedd_pkg::CLS_EXT_W-1:0] cu_ext, cv_ext;

  always_comb begin
    head      = q2b_i.cmd;
    pop       = (state_q == ST_IDLE) && q2b_i.valid;
    map_rd_en = pop && (head.op == cedd_pkg::OP_EDGE);
    src_ext   = cedd_pkg::ADDR_EXT_W'(head.vertex);
    tgt_ext   = cedd_pkg::ADDR_EXT_W'(head.target);
    src_addr  = src_ext[VTX_AW-1:0];
    tgt_addr  = tgt_ext[VTX_AW-1:0];
    cls_ext   = cedd_pkg::CLS_EXT_W'(head.cls);

    sweep_map  = SWC_W'(sweep_q) < SWC_W'(MAX_VERTICES);
    sweep_pair = SWC_W'(sweep_q) < SWC_W'(MAX_CLASSES);
    sweep_last = sweep_q == SW_W'(SWEEP_LEN - 1);

    hit = src_ok_q && tgt_ok_q && map_a_q[CLS_W] && map_b_q[CLS_W]
          && (map_a_q[CLS_W-1:0] != map_b_q[CLS_W-1:0]);
    new_link = (state_q == ST_PAIR) && !pair_row_q[cv_q];

    map_we = 1'b0;
    map_wa = src_addr;
    map_wd = '0;
    priority if (state_q == ST_SWEEP) begin
      map_we = sweep_map;
      map_wa = sweep_q[VTX_AW-1:0];
      map_wd = '0;
    end else if (pop && head.op == cedd_pkg::OP_ASSIGN && head.src_ok) begin
      map_we = 1'b1;
      map_wd = head.cls_ok ? {1'b1, cls_ext[CLS_W-1:0]} : '0;
    end

    pair_rd_en = (state_q == ST_MAP) && hit;
    pair_we    = 1'b0;
    pair_wa    = cu_q;
    pair_wd    = pair_row_q | (MAX_CLASSES'(1) << cv_q);
    priority if (state_q == ST_SWEEP) begin
      pair_we = sweep_pair;
      pair_wa = sweep_q[CLS_W-1:0];
      pair_wd = '0;
    end else if (new_link) begin
      pair_we = 1'b1;
    end

    cu_ext = cedd_pkg::CLS_EXT_W'(cu_q);
    cv_ext = cedd_pkg::CLS_EXT_W'(cv_q);
  end

  // vertex class map: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (map_rd_en) begin
      map_a_q <= map_mem[src_addr];
      map_b_q <= map_mem[tgt_addr];
    end
  end

  // pair bitmap, one row per source class
  always_ff @(posedge clk_i) begin
    if (pair_we) begin
      pair_mem[pair_wa] <= pair_wd;
    end
    if (pair_rd_en) begin
      pair_row_q <= pair_mem[map_a_q[CLS_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_SWEEP;
      sweep_q    <= '0;
      link_q     <= '0;
      src_ok_q   <= 1'b0;
      tgt_ok_q   <= 1'b0;
      cu_q       <= '0;
      cv_q       <= '0;
      valid_q    <= 1'b0;
      src_cls_q  <= '0;
      tgt_cls_q  <= '0;
      link_out_q <= '0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        ST_SWEEP: begin
          if (sweep_last) begin
            sweep_q <= '0;
            state_q <= ST_IDLE;
          end else begin
            sweep_q <= sweep_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (q2b_i.valid) begin
            unique case (head.op)
              cedd_pkg::OP_EDGE: begin
                src_ok_q <= head.src_ok;
                tgt_ok_q <= head.tgt_ok;
                state_q  <= ST_MAP;
              end
              cedd_pkg::OP_CLEAR: begin
                link_q  <= '0;
                sweep_q <= '0;
                state_q <= ST_SWEEP;
              end
              default: begin
              end
            endcase
          end
        end
        ST_MAP: begin
          if (hit) begin
            cu_q    <= map_a_q[CLS_W-1:0];
            cv_q    <= map_b_q[CLS_W-1:0];
            state_q <= ST_PAIR;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_PAIR: begin
          if (new_link) begin
            valid_q    <= 1'b1;
            src_cls_q  <= cu_ext[cedd_pkg::CLASS_OUT_W-1:0];
            tgt_cls_q  <= cv_ext[cedd_pkg::CLASS_OUT_W-1:0];
            link_out_q <= link_q;
            link_q     <= link_q + 1'b1;
          end
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign b2f_o.pop      = pop;
  assign b2f_o.sweeping = state_q == ST_SWEEP;

  assign valid_o        = valid_q;
  assign source_class_o = src_cls_q;
  assign target_class_o = tgt_cls_q;
  assign link_index_o   = link_out_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q == ST_PAIR))
    else $error("result strobe without a pair lookup");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> source_class_o != target_class_o)
    else $error("link between equal classes");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> link_q == cedd_pkg::LINK_W'(link_index_o + 1'b1))
    else $error("link counter out of step with result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> state_q == ST_IDLE && !b2f_o.sweeping)
    else $error("command taken while not idle");
`endif

endmodule

`default_nettype wire

// ===== sv/condensation_edge_dedup_core.sv =====
`default_nettype none

// condensation graph edge builder
// command channel: drive operation_i, vertex_i, class_code_i and target_vertex_i with start;
// the transfer happens at a rising edge where start is high and busy is low.
// operation 0 assigns a class (or unassigned) to a vertex, 1 looks up an edge,
// 2 clears the vertex map, the pair bitmap and the link counter, 3 is dropped.
// result channel: valid_o is high for exactly one cycle with source_class_o,
// target_class_o and link_index_o for each new class pair; there is no backpressure.
// items pass through a two-entry command queue into an executor that does one at a time:
// an assign is done in the idle state, an edge passes the map state and, when both endpoint
// classes are assigned and differ, the pair state (two map reads, then a pair bitmap
// read-modify-write); a new item is taken only when the executor is back in idle.
// with the queue empty, an accepted edge is written into the queue, popped by the idle
// executor and passed through the map and pair states before its new link shows on valid_o.
// a clear walks both stores, clearing every address of each, with busy high for that sweep.
// after reset the same sweep runs first, so busy is high throughout it.
module condensation_edge_dedup_core #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_CLASSES  = 64
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     start,
  output logic                                          busy,
  input  wire logic [cedd_pkg::OPERATION_W-1:0]         operation_i,
  input  wire logic [cedd_pkg::VERTEX_W-1:0]            vertex_i,
  input  wire logic signed [cedd_pkg::CLASS_CODE_W-1:0] class_code_i,
  input  wire logic [cedd_pkg::VERTEX_W-1:0]            target_vertex_i,
  output logic                                          valid_o,
  output logic [cedd_pkg::CLASS_OUT_W-1:0]              source_class_o,
  output logic [cedd_pkg::CLASS_OUT_W-1:0]              target_class_o,
  output logic [cedd_pkg::LINK_W-1:0]                   link_index_o
);

  cedd_pkg::q2b_t q2b;
  cedd_pkg::b2f_t b2f;

  cedd_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_CLASSES  (MAX_CLASSES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation_i),
    .vertex_i        (vertex_i),
    .class_code_i    (class_code_i),
    .target_vertex_i (target_vertex_i),
    .q2b_o           (q2b),
    .b2f_i           (b2f)
  );

  cedd_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_CLASSES  (MAX_CLASSES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q2b_i          (q2b),
    .b2f_o          (b2f),
    .valid_o        (valid_o),
    .source_class_o (source_class_o),
    .target_class_o (target_class_o),
    .link_index_o   (link_index_o)
  );

endmodule

`default_nettype wire

// ===== bench/condensation_edge_dedup_core_tb.sv =====
module condensation_edge_dedup_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_VERTICES  = 1024;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned RANDOM_CMDS = 1800;
  localparam int unsigned HOT_SET     = 20;

  // operation code that the block drops
  localparam logic [cedd_pkg::OPERATION_W-1:0] OP_UNUSED  = 2'd3;
  localparam logic signed [cedd_pkg::CLASS_CODE_W-1:0] UNASSIGNED = -7'sd1;

  typedef struct packed {
    logic [cedd_pkg::OPERATION_W-1:0]  op;
    logic [cedd_pkg::VERTEX_W-1:0]     vertex;
    logic [cedd_pkg::CLASS_CODE_W-1:0] class_code;
    logic [cedd_pkg::VERTEX_W-1:0]     target;
  } graph_cmd_t;

  typedef struct packed {
    logic [cedd_pkg::CLASS_OUT_W-1:0] src_cls;
    logic [cedd_pkg::CLASS_OUT_W-1:0] tgt_cls;
    logic [cedd_pkg::LINK_W-1:0]      index;
  } link_t;

  logic                                   clk_i           = 1'b0;
  logic                                   rst_ni          = 1'b0;
  logic                                   start           = 1'b0;
  logic                                   busy;
  logic [cedd_pkg::OPERATION_W-1:0]         operation_i     = '0;
  logic [cedd_pkg::VERTEX_W-1:0]            vertex_i        = '0;
  logic signed [cedd_pkg::CLASS_CODE_W-1:0] class_code_i    = '0;
  logic [cedd_pkg::VERTEX_W-1:0]            target_vertex_i = '0;
  logic                                   valid_o;
  logic [cedd_pkg::CLASS_OUT_W-1:0]         source_class_o;
  logic [cedd_pkg::CLASS_OUT_W-1:0]         target_class_o;
  logic [cedd_pkg::LINK_W-1:0]              link_index_o;

  // predictor state
  logic signed [cedd_pkg::CLASS_CODE_W-1:0] class_map [0:N_VERTICES-1];
  logic [4095:0]                          pair_marked;
  logic [cedd_pkg::LINK_W-1:0]              links_made;

  graph_cmd_t  queued_cmds [$];
  link_t       pending_links [$];
  graph_cmd_t  on_wire;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned errors     = 0;
  int unsigned cycles     = 0;

  condensation_edge_dedup_core i_dut (.*);

  always #4 clk_i = ~clk_i;

  function automatic void wipe_graph();
    for (int v = 0; v < N_VERTICES; v++) class_map[v] = UNASSIGNED;
    pair_marked = '0;
    links_made  = '0;
  endfunction

  function automatic void apply_command(input graph_cmd_t c);
    logic signed [cedd_pkg::CLASS_CODE_W-1:0] src, tgt;
    link_t lk;
    case (c.op)
      cedd_pkg::OP_ASSIGN: begin
        // any negative class code stores unassigned
        class_map[c.vertex] = ($signed(c.class_code) < 0) ? UNASSIGNED : $signed(c.class_code);
      end
      cedd_pkg::OP_EDGE: begin
        src = class_map[c.vertex];
        tgt = class_map[c.target];
        if (src >= 0 && tgt >= 0 && src != tgt && !pair_marked[{src[5:0], tgt[5:0]}]) begin
          pair_marked[{src[5:0], tgt[5:0]}] = 1'b1;
          lk.src_cls = src[5:0];
          lk.tgt_cls = tgt[5:0];
          lk.index   = links_made;
          pending_links.push_back(lk);
          links_made = links_made + 1'b1;
        end
      end
      cedd_pkg::OP_CLEAR: wipe_graph();
      default: ;
    endcase
  endfunction

  function automatic void queue_cmd(input logic [cedd_pkg::OPERATION_W-1:0] op,
                                    input logic [cedd_pkg::VERTEX_W-1:0] v,
                                    input logic [cedd_pkg::CLASS_CODE_W-1:0] cls,
                                    input logic [cedd_pkg::VERTEX_W-1:0] t);
    graph_cmd_t c;
    c.op         = op;
    c.vertex     = v;
    c.class_code = cls;
    c.target     = t;
    queued_cmds.push_back(c);
  endfunction

  function automatic logic [cedd_pkg::VERTEX_W-1:0] any_vertex();
    return cedd_pkg::VERTEX_W'($urandom_range(0, N_VERTICES - 1));
  endfunction

  function automatic logic [cedd_pkg::CLASS_CODE_W-1:0] any_code();
    return cedd_pkg::CLASS_CODE_W'($urandom);
  endfunction

  function automatic logic [cedd_pkg::CLASS_CODE_W-1:0] random_class();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 88) return cedd_pkg::CLASS_CODE_W'($urandom_range(0, 63));
    else if (pick < 94) return UNASSIGNED;
    else return cedd_pkg::CLASS_CODE_W'($urandom_range(64, 127));  // other negative codes
  endfunction

  function automatic void queue_directed();
    queue_cmd(cedd_pkg::OP_ASSIGN, 10'd0,    7'd0,        10'd0);
    queue_cmd(cedd_pkg::OP_ASSIGN, 10'd1023, 7'd63,       10'd1023);
    queue_cmd(cedd_pkg::OP_ASSIGN, 10'd5,    7'd63,       10'd0);
    queue_cmd(cedd_pkg::OP_ASSIGN, 10'd6,    UNASSIGNED,  10'd0);
    queue_cmd(cedd_pkg::OP_ASSIGN, 10'd7,    7'h40,       10'd0);  // most negative code
    queue_cmd(cedd_pkg::OP_EDGE,   10'd0,    7'd0,        10'd1023);
    queue_cmd(cedd_pkg::OP_EDGE,   10'd0,    7'd0,        10'd1023);  // pair already linked
    queue_cmd(cedd_pkg::OP_EDGE,   10'd1023, 7'd0,        10'd0);     // reversed pair is new
    queue_cmd(cedd_pkg::OP_EDGE,   10'd1023, 7'd0,        10'd5);     // same class
    queue_cmd(cedd_pkg::OP_EDGE,   10'd0,    7'd0,        10'd6);     // unassigned target
    queue_cmd(cedd_pkg::OP_EDGE,   10'd7,    7'd0,        10'd0);     // unassigned source
    queue_cmd(cedd_pkg::OP_EDGE,   10'd0,    7'd0,        10'd0);
    queue_cmd(OP_UNUSED,           10'h3FF,  7'h7F,       10'h3FF);
    queue_cmd(cedd_pkg::OP_EDGE,   10'd5,    7'd0,        10'd0);     // seen through another vertex
    queue_cmd(cedd_pkg::OP_ASSIGN, 10'd1023, -7'sd2,      10'd0);
    queue_cmd(cedd_pkg::OP_EDGE,   10'd0,    7'd0,        10'd1023);
    queue_cmd(cedd_pkg::OP_CLEAR,  10'd0,    7'd0,        10'd0);
    queue_cmd(cedd_pkg::OP_EDGE,   10'd1023, 7'd0,        10'd5);     // map wiped
    queue_cmd(cedd_pkg::OP_ASSIGN, 10'd0,    7'd1,        10'd0);
    queue_cmd(cedd_pkg::OP_ASSIGN, 10'd1,    7'd2,        10'd0);
    queue_cmd(cedd_pkg::OP_EDGE,   10'd0,    7'd0,        10'd1);     // link number restarts
    queue_cmd(cedd_pkg::OP_EDGE,   10'd1,    7'd0,        10'd0);
  endfunction

  function automatic void queue_random(input int unsigned n_cmds);
    logic [cedd_pkg::VERTEX_W-1:0] hot [0:HOT_SET-1];
    int unsigned made, span, pick;
    made = 0;
    while (made < n_cmds) begin
      foreach (hot[h]) hot[h] = any_vertex();
      foreach (hot[h]) begin
        queue_cmd(cedd_pkg::OP_ASSIGN, hot[h], random_class(), any_vertex());
        made++;
      end
      span = $urandom_range(60, 220);
      for (int n = 0; n < span; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 52) begin
          queue_cmd(cedd_pkg::OP_EDGE, hot[$urandom_range(0, HOT_SET - 1)], any_code(),
                    hot[$urandom_range(0, HOT_SET - 1)]);
        end else if (pick < 58) begin
          // edge to a vertex that is most likely unmapped
          queue_cmd(cedd_pkg::OP_EDGE, hot[$urandom_range(0, HOT_SET - 1)], any_code(),
                    any_vertex());
        end else if (pick < 93) begin
          queue_cmd(cedd_pkg::OP_ASSIGN, hot[$urandom_range(0, HOT_SET - 1)], random_class(),
                    any_vertex());
        end else if (pick < 97) begin
          queue_cmd(cedd_pkg::OP_ASSIGN, any_vertex(), random_class(), any_vertex());
        end else begin
          queue_cmd(OP_UNUSED, any_vertex(), any_code(), any_vertex());
          made--;
        end
        made++;
      end
      // some phases keep counting links across the next working set
      if ($urandom_range(0, 9) < 7) begin
        queue_cmd(cedd_pkg::OP_CLEAR, any_vertex(), any_code(), any_vertex());
        made++;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : drive_cmds
    logic go;
    if (!rst_ni) begin
      start           <= 1'b0;
      operation_i     <= '0;
      vertex_i        <= '0;
      class_code_i    <= '0;
      target_vertex_i <= '0;
    end else begin
      go = start;
      if (start && !busy) begin
        apply_command(on_wire);
        go = 1'b0;
      end
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (queued_cmds.size() > 0) begin
          on_wire = queued_cmds.pop_front();
          operation_i     <= on_wire.op;
          vertex_i        <= on_wire.vertex;
          class_code_i    <= on_wire.class_code;
          target_vertex_i <= on_wire.target;
          go = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            case ($urandom_range(0, 9))
              0, 1, 2, 3: gap_left = 0;
              9:          gap_left = $urandom_range(10, 30);
              default:    gap_left = $urandom_range(1, 6);
            endcase
          end
        end
      end
      start <= go;
    end
  end

  always @(posedge clk_i) begin : check_links
    link_t want;
    if (rst_ni && valid_o) begin
      if (pending_links.size() == 0) begin
        $display("%0t: link with none expected: src %0d tgt %0d index %0d", $time,
                 source_class_o, target_class_o, link_index_o);
        errors++;
      end else begin
        want = pending_links.pop_front();
        if (source_class_o !== want.src_cls) begin
          $display("%0t: source_class expected %0d got %0d", $time, want.src_cls,
                   source_class_o);
          errors++;
        end
        if (target_class_o !== want.tgt_cls) begin
          $display("%0t: target_class expected %0d got %0d", $time, want.tgt_cls,
                   target_class_o);
          errors++;
        end
        if (link_index_o !== want.index) begin
          $display("%0t: link_index expected %0d got %0d", $time, want.index,
                   link_index_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d commands and %0d links outstanding", $time,
               queued_cmds.size(), pending_links.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    wipe_graph();
    queue_directed();
    queue_random(RANDOM_CMDS);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (queued_cmds.size() > 0 || start) @(negedge clk_i);
    while (pending_links.size() > 0) @(negedge clk_i);
    // catch late or spurious strobes
    repeat (16) @(negedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/cedd_pkg.sv
sv/cedd_front.sv
sv/cedd_back.sv
sv/condensation_edge_dedup_core.sv
bench/condensation_edge_dedup_core_tb.sv
